>>> rtl/assert_macros.svh
// Assertion shorthands shared by the RTL modules.
// Every property is sampled on the rising clock and is switched off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a plain condition at every edge.
`define DTF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define DTF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define DTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/dtf_pkg.sv
`default_nettype none

package dtf_pkg;

    localparam int FRAC_BITS       = 28;
    localparam int MAX_FRAC_DIGITS = 9;
    localparam int VALUE_W         = 31;
    localparam int CHAR_W          = 8;
    localparam int COUNT_W         = 4;
    localparam int INT_W           = 2;
    localparam int INT_SAT         = 3;
    localparam int QUEUE_DEPTH     = 4;

    // Power of ten, for elaboration-time sizing only
    function automatic longint unsigned pow10_const(int k);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < k; i++)
        begin
            p = p * 10;
        end
        return p;
    endfunction

    // Width that holds the largest divisor and the kept fraction digits
    localparam int DEN_W = $clog2(pow10_const(MAX_FRAC_DIGITS) + 1);
    localparam int REM_W = DEN_W + 1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_CHAR = 2'd1,
        STATUS_RANGE    = 2'd2
    } status_t;

    typedef enum logic {
        PHASE_LEAD = 1'b0,
        PHASE_BODY = 1'b1
    } phase_t;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    // One finished string, handed from the parser to the divider
    typedef struct packed {
        logic                negative;
        logic [INT_W-1:0]    int_part;
        logic [DEN_W-1:0]    frac;
        logic [COUNT_W-1:0]  count;
        status_t             status;
    } job_t;

    // Divisor 10^k for k kept fraction digits
    function automatic logic [DEN_W-1:0] pow10_lut(logic [COUNT_W-1:0] k);
        logic [63:0] p;
        unique case (k)
            4'd0:    p = 64'd1;
            4'd1:    p = 64'd10;
            4'd2:    p = 64'd100;
            4'd3:    p = 64'd1000;
            4'd4:    p = 64'd10000;
            4'd5:    p = 64'd100000;
            4'd6:    p = 64'd1000000;
            4'd7:    p = 64'd10000000;
            4'd8:    p = 64'd100000000;
            4'd9:    p = 64'd1000000000;
            4'd10:   p = 64'd10000000000;
            4'd11:   p = 64'd100000000000;
            4'd12:   p = 64'd1000000000000;
            4'd13:   p = 64'd10000000000000;
            4'd14:   p = 64'd100000000000000;
            4'd15:   p = 64'd1000000000000000;
            default: p = 64'd1;
        endcase
        return p[DEN_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/dtf_front.sv
`default_nettype none

`include "assert_macros.svh"

module dtf_front
    import dtf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CHAR_W-1:0] character,
    input  wire logic              queue_full,
    output logic                   push,
    output job_t                   job
);

    localparam int PROD_W = DEN_W + 4;

    phase_t               phase_reg, phase_next;
    logic                 negative_reg, negative_next;
    logic                 point_reg, point_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [INT_W-1:0]     int_reg, int_next;
    logic [DEN_W-1:0]     frac_reg, frac_next;
    logic                 bad_reg, bad_next;

    logic                 accept;
    logic                 is_end;
    logic                 is_space;
    logic                 is_digit;
    logic                 is_lead;
    logic [3:0]           digit;
    logic [5:0]           int_prod;
    logic [PROD_W-1:0]    frac_prod;
    logic                 over;

    // Classify the byte
    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign is_end    = (character == CHAR_NUL);
    assign is_space  = (character == CHAR_SPACE) ||
                       (character >= CHAR_TAB && character <= CHAR_CR);
    assign is_digit  = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
    assign is_lead   = (phase_reg == PHASE_LEAD);
    assign digit     = 4'(character - CHAR_ZERO);
    assign int_prod  = 6'(int_reg) * 6'd10 + 6'(digit);
    assign frac_prod = PROD_W'(frac_reg) * PROD_W'(10) + PROD_W'(digit);

    // Next state of the parser
    always_comb
    begin
        phase_next    = phase_reg;
        negative_next = negative_reg;
        point_next    = point_reg;
        count_next    = count_reg;
        int_next      = int_reg;
        frac_next     = frac_reg;
        bad_next      = bad_reg;
        if (accept)
        begin
            if (is_end)
            begin
                phase_next    = PHASE_LEAD;
                negative_next = 1'b0;
                point_next    = 1'b0;
                count_next    = '0;
                int_next      = '0;
                frac_next     = '0;
                bad_next      = 1'b0;
            end
            else if (!bad_reg && !(is_lead && is_space))
            begin
                phase_next = PHASE_BODY;
                if (is_lead && character == CHAR_PLUS)
                begin
                    phase_next = PHASE_BODY;
                end
                else if (is_lead && character == CHAR_MINUS)
                begin
                    negative_next = 1'b1;
                end
                else if (character == CHAR_POINT)
                begin
                    if (point_reg)
                    begin
                        bad_next = 1'b1;
                    end
                    else
                    begin
                        point_next = 1'b1;
                    end
                end
                else if (is_digit)
                begin
                    if (!point_reg)
                    begin
                        // Saturate the integer part
                        int_next = (int_prod > 6'(INT_SAT)) ? INT_W'(INT_SAT) : int_prod[INT_W-1:0];
                    end
                    else if (count_reg < COUNT_W'(MAX_FRAC_DIGITS))
                    begin
                        frac_next  = frac_prod[DEN_W-1:0];
                        count_next = count_reg + 1'b1;
                    end
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
        end
    end

    // Hand the finished string on at the terminating NUL
    always_comb
    begin
        over          = (int_reg == INT_W'(INT_SAT)) || (int_reg == 2'd2 && frac_reg != '0);
        push          = accept && is_end;
        job.negative  = negative_reg;
        job.int_part  = int_reg;
        job.frac      = frac_reg;
        job.count     = count_reg;
        if (bad_reg)
        begin
            job.status = STATUS_BAD_CHAR;
        end
        else if (over)
        begin
            job.status = STATUS_RANGE;
        end
        else
        begin
            job.status = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PHASE_LEAD;
            negative_reg <= 1'b0;
            point_reg    <= 1'b0;
            count_reg    <= '0;
            int_reg      <= '0;
            frac_reg     <= '0;
            bad_reg      <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            negative_reg <= negative_next;
            point_reg    <= point_next;
            count_reg    <= count_next;
            int_reg      <= int_next;
            frac_reg     <= frac_next;
            bad_reg      <= bad_next;
        end
    end

    `DTF_ASSERT_NEXT(a_bad_sticky, clk, rst_n, bad_reg && !push, bad_reg, "bad character flag dropped before end of string")
    `DTF_ASSERT_IMPL(a_lead_clean, clk, rst_n, phase_reg == PHASE_LEAD, !negative_reg && !point_reg && int_reg == '0 && count_reg == '0 && !bad_reg, "state left over in leading phase")
    `DTF_ASSERT(a_count_bound, clk, rst_n, count_reg <= COUNT_W'(MAX_FRAC_DIGITS), "fraction digit count beyond limit")

endmodule

`default_nettype wire

>>> rtl/dtf_queue.sv
`default_nettype none

`include "assert_macros.svh"

module dtf_queue
    import dtf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_data,
    output logic      full,
    input  wire logic pop,
    output logic      valid,
    output job_t      pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign valid    = (cnt_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Store the incoming job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `DTF_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full, "push into full queue")
    `DTF_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, valid, "pop from empty queue")

endmodule

`default_nettype wire

>>> rtl/dtf_back.sv
`default_nettype none

`include "assert_macros.svh"

module dtf_back
    import dtf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  job_valid,
    input  wire job_t                  job,
    output logic                       job_pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [VALUE_W-1:0]  value,
    output logic [1:0]                 status
);

    localparam int NSTG = FRAC_BITS + 1;

    logic                   advance;

    logic                   stg_valid_reg  [NSTG];
    logic [DEN_W-1:0]       stg_rem_reg    [NSTG];
    logic [DEN_W-1:0]       stg_den_reg    [NSTG];
    logic [FRAC_BITS-1:0]   stg_q_reg      [NSTG];
    logic                   stg_neg_reg    [NSTG];
    logic [INT_W-1:0]       stg_int_reg    [NSTG];
    status_t                stg_status_reg [NSTG];

    logic                   out_valid_reg;
    logic [VALUE_W-1:0]     value_reg, value_next;
    status_t                status_reg;

    logic [REM_W-1:0]       last_shifted;
    logic                   round_up;
    logic [FRAC_BITS:0]     q_round;
    logic [VALUE_W-1:0]     mag;

    // Move the whole pipeline whenever the output register is free
    assign advance = !out_valid_reg || out_ready;
    assign job_pop = advance && job_valid;

    // Load a job into the first stage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stg_rem_reg[0]    <= job.frac;
            stg_den_reg[0]    <= pow10_lut(job.count);
            stg_q_reg[0]      <= '0;
            stg_neg_reg[0]    <= job.negative;
            stg_int_reg[0]    <= job.int_part;
            stg_status_reg[0] <= job.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            stg_valid_reg[0] <= job_valid;
        end
    end

    // One quotient bit per stage: restoring long division
    for (genvar s = 1; s < NSTG; s++)
    begin : g_stage
        logic [REM_W-1:0] shifted;
        logic             take;

        assign shifted = {stg_rem_reg[s-1], 1'b0};
        assign take    = (shifted >= {1'b0, stg_den_reg[s-1]});

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                stg_rem_reg[s]    <= take ? DEN_W'(shifted - {1'b0, stg_den_reg[s-1]})
                                          : DEN_W'(shifted);
                stg_den_reg[s]    <= stg_den_reg[s-1];
                stg_q_reg[s]      <= {stg_q_reg[s-1][FRAC_BITS-2:0], take};
                stg_neg_reg[s]    <= stg_neg_reg[s-1];
                stg_int_reg[s]    <= stg_int_reg[s-1];
                stg_status_reg[s] <= stg_status_reg[s-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stg_valid_reg[s] <= 1'b0;
            end
            else if (advance)
            begin
                stg_valid_reg[s] <= stg_valid_reg[s-1];
            end
        end
    end

    // Round half up on the remainder, add the integer part, apply the sign; zero on any error
    always_comb
    begin
        last_shifted = {stg_rem_reg[NSTG-1], 1'b0};
        round_up     = (last_shifted >= {1'b0, stg_den_reg[NSTG-1]});
        q_round      = {1'b0, stg_q_reg[NSTG-1]} + (FRAC_BITS + 1)'(round_up);
        mag          = (VALUE_W'(stg_int_reg[NSTG-1]) << FRAC_BITS) + VALUE_W'(q_round);
        if (stg_status_reg[NSTG-1] != STATUS_OK)
        begin
            value_next = '0;
        end
        else if (stg_neg_reg[NSTG-1])
        begin
            value_next = VALUE_W'(0) - mag;
        end
        else
        begin
            value_next = mag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            value_reg  <= value_next;
            status_reg <= stg_status_reg[NSTG-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stg_valid_reg[NSTG-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = $signed(value_reg);
    assign status    = status_reg;

    `DTF_ASSERT_IMPL(a_error_zero, clk, rst_n, out_valid_reg && status_reg != STATUS_OK, value_reg == '0, "nonzero value with error status")
    `DTF_ASSERT_NEXT(a_load_first, clk, rst_n, job_pop, stg_valid_reg[0], "popped job not loaded into first stage")

endmodule

`default_nettype wire

>>> rtl/decimal_text_to_fixed.sv
// decimal_text_to_fixed: decimal text in, signed fixed point out.
// Input channel (in_valid / in_ready / character): one byte per transfer.
// Leading white space and one sign are absorbed; digits and one '.' follow;
// a NUL byte closes the string and produces exactly one result.
// Output channel (out_valid / out_ready / value / status): value carries
// FRAC_BITS fraction bits in two's complement; status is ok, invalid
// character or magnitude above two, and value is zero on any error.
// Throughput: one byte per cycle while in_ready is high, NUL included,
// so a result can leave every cycle unless the output stalls. The parser
// handles a byte in the cycle it arrives; the divider is a pipeline of
// FRAC_BITS one-bit restoring steps. After its NUL a result passes the
// queue, the load stage, the divider steps and the output register.
// A stalled receiver holds the output register and freezes the divider
// pipeline; a four-entry queue between parser and divider keeps accepting
// bytes until it fills, then in_ready drops.
// Reset clears the parser, the queue and all valid flags; the next byte
// starts a fresh string.
`default_nettype none

module decimal_text_to_fixed
    import dtf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [CHAR_W-1:0]     character,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [VALUE_W-1:0]  value,
    output logic [1:0]                 status
);

    logic queue_full;
    logic push;
    job_t push_job;
    logic pop;
    logic queue_valid;
    job_t pop_job;

    // Parse bytes and build jobs
    dtf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .character  (character),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    // Decouple parser and divider
    dtf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (queue_full),
        .pop       (pop),
        .valid     (queue_valid),
        .pop_data  (pop_job)
    );

    // Convert the fraction and present the result
    dtf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_valid),
        .job       (pop_job),
        .job_pop   (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .status    (status)
    );

endmodule

`default_nettype wire
